/* rtl/rc4_pkg.sv */
// Shared types and constants for the RC4 keystream cipher.
package rc4_pkg;

    // Key storage and schedule limits
    localparam int KEY_BYTES_MAX  = 32;
    localparam int KEY_BYTES_HELD = 32;
    localparam int KEY_LEN_CAP    = (KEY_BYTES_MAX < KEY_BYTES_HELD) ? KEY_BYTES_MAX
                                                                     : KEY_BYTES_HELD;
    localparam int KEY_IDX_W      = $clog2(KEY_BYTES_HELD);

    // Configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int KEY_LEN_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

    // Input opcodes
    localparam logic OPC_CRYPT = 1'b0;
    localparam logic OPC_REKEY = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_RD_J,
        ST_D_WR_I,
        ST_D_WR_J,
        ST_K_FILL,
        ST_K_RD_S,
        ST_K_RD_J,
        ST_K_WR_S,
        ST_K_WR_J
    } ctrl_state_t;

    // Datapath commands, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_DATA_START,
        OP_DATA_RD_J,
        OP_DATA_WR_I,
        OP_DATA_WR_J,
        OP_KS_INIT,
        OP_KS_FILL,
        OP_KS_RD_S,
        OP_KS_RD_J,
        OP_KS_WR_S,
        OP_KS_WR_J
    } dp_op_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic step_last;
    } dp_status_t;

endpackage

/* rtl/rc4_ctrl.sv */
// Sequencing state machine for data steps and the key schedule.
module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_opcode,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_op_t     dp_op,
    input  dp_status_t dp_status
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        load_out;

    // State and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        dp_op      = OP_NONE;
        s_ready    = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // a pending result does not hold off the next transfer
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode == OPC_REKEY) begin
                        dp_op      = OP_KS_INIT;
                        state_next = ST_K_FILL;
                    end else begin
                        dp_op      = OP_DATA_START;
                        state_next = ST_D_RD_J;
                    end
                end
            end
            ST_D_RD_J: begin
                dp_op      = OP_DATA_RD_J;
                state_next = ST_D_WR_I;
            end
            ST_D_WR_I: begin
                dp_op      = OP_DATA_WR_I;
                state_next = ST_D_WR_J;
            end
            ST_D_WR_J: begin
                // result register is free or drains this cycle
                if (!out_valid_reg || m_ready) begin
                    dp_op      = OP_DATA_WR_J;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_K_FILL: begin
                dp_op = OP_KS_FILL;
                if (dp_status.step_last) begin
                    state_next = ST_K_RD_S;
                end
            end
            ST_K_RD_S: begin
                dp_op      = OP_KS_RD_S;
                state_next = ST_K_RD_J;
            end
            ST_K_RD_J: begin
                dp_op      = OP_KS_RD_J;
                state_next = ST_K_WR_S;
            end
            ST_K_WR_S: begin
                dp_op      = OP_KS_WR_S;
                state_next = ST_K_WR_J;
            end
            ST_K_WR_J: begin
                dp_op      = OP_KS_WR_J;
                state_next = dp_status.step_last ? ST_IDLE : ST_K_RD_S;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set when the byte is loaded, cleared on transfer
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

/* rtl/rc4_dp.sv */
// Permutation memory, indices, key registers and result register.
module rc4_dp
    import rc4_pkg::*;
#(
    parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [7:0]            s_data_in,
    output logic [7:0]            m_data_out,
    input  dp_op_t                dp_op,
    output dp_status_t            dp_status
);

    // Longest usable key: the configured limit or the bytes held, whichever is less
    localparam int LEN_CAP = (KEY_BYTES_MAX < KEY_BYTES_HELD) ? KEY_BYTES_MAX
                                                              : KEY_BYTES_HELD;

    // Permutation memory with two registered read ports
    logic [7:0] mem [256];
    logic       mem_we;
    logic [7:0] wr_addr, wr_data;
    logic       rd_a_en, rd_b_en;
    logic [7:0] rd_a_addr, rd_b_addr;
    logic [7:0] rd_a_reg, rd_b_reg;

    // Key registers
    logic [CFG_DATA_W-1:0] key_word_reg [4];
    logic [KEY_LEN_W-1:0]  key_len_reg;

    // Indices and counters
    logic [7:0]           i_reg, i_next;
    logic [7:0]           j_reg, j_next;
    logic [7:0]           cnt_reg, cnt_next;
    logic [KEY_IDX_W-1:0] k_reg, k_next;

    // Data byte, forwarding for the output read, result
    logic [7:0] data_reg, data_next;
    logic [7:0] fwd_val_reg, fwd_val_next;
    logic       fwd_hit_reg, fwd_hit_next;
    logic [7:0] dout_reg, dout_next;

    logic [8*KEY_BYTES_HELD-1:0] key_vec;
    logic [7:0]                  key_byte;
    logic [KEY_LEN_W-1:0]        eff_len;
    logic [KEY_LEN_W-1:0]        k_inc;
    logic [7:0]                  t_addr;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_word_reg[0] <= '0;
            key_word_reg[1] <= '0;
            key_word_reg[2] <= '0;
            key_word_reg[3] <= '0;
            key_len_reg     <= KEY_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_KEY_WORD_0: key_word_reg[0] <= cfg_wdata;
                CFG_KEY_WORD_1: key_word_reg[1] <= cfg_wdata;
                CFG_KEY_WORD_2: key_word_reg[2] <= cfg_wdata;
                CFG_KEY_WORD_3: key_word_reg[3] <= cfg_wdata;
                CFG_KEY_LENGTH: key_len_reg     <= cfg_wdata[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Key byte select and effective length (zero acts as one, capped)
    assign key_vec  = {key_word_reg[3], key_word_reg[2], key_word_reg[1], key_word_reg[0]};
    assign key_byte = key_vec[{k_reg, 3'b000} +: 8];

    always_comb begin
        if (key_len_reg == '0) begin
            eff_len = KEY_LEN_W'(1);
        end else if (key_len_reg > KEY_LEN_W'(LEN_CAP)) begin
            eff_len = KEY_LEN_W'(LEN_CAP);
        end else begin
            eff_len = key_len_reg;
        end
    end

    assign k_inc  = {1'b0, k_reg} + KEY_LEN_W'(1);
    assign t_addr = rd_a_reg + rd_b_reg;

    // Memory ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (rd_b_en) begin
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg   <= '0;
            j_reg   <= '0;
            cnt_reg <= '0;
            k_reg   <= '0;
        end else begin
            i_reg   <= i_next;
            j_reg   <= j_next;
            cnt_reg <= cnt_next;
            k_reg   <= k_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        data_reg    <= data_next;
        fwd_val_reg <= fwd_val_next;
        fwd_hit_reg <= fwd_hit_next;
        dout_reg    <= dout_next;
    end

    // Per-command datapath operation
    always_comb begin
        mem_we       = 1'b0;
        wr_addr      = cnt_reg;
        wr_data      = cnt_reg;
        rd_a_en      = 1'b0;
        rd_a_addr    = cnt_reg;
        rd_b_en      = 1'b0;
        rd_b_addr    = j_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        data_next    = data_reg;
        fwd_val_next = fwd_val_reg;
        fwd_hit_next = fwd_hit_reg;
        dout_next    = dout_reg;
        unique case (dp_op)
            OP_NONE: ;
            // i advances, read P[i]
            OP_DATA_START: begin
                i_next    = i_reg + 8'd1;
                rd_a_en   = 1'b1;
                rd_a_addr = i_reg + 8'd1;
                data_next = s_data_in;
            end
            // j += a, read P[j]
            OP_DATA_RD_J: begin
                j_next    = j_reg + rd_a_reg;
                rd_b_en   = 1'b1;
                rd_b_addr = j_reg + rd_a_reg;
            end
            // P[i] = b; read P[a+b] and note whether the swap hits it
            OP_DATA_WR_I: begin
                mem_we       = 1'b1;
                wr_addr      = i_reg;
                wr_data      = rd_b_reg;
                rd_b_en      = 1'b1;
                rd_b_addr    = t_addr;
                fwd_hit_next = (t_addr == j_reg) || (t_addr == i_reg);
                fwd_val_next = (t_addr == j_reg) ? rd_a_reg : rd_b_reg;
            end
            // P[j] = a; result byte
            OP_DATA_WR_J: begin
                mem_we    = 1'b1;
                wr_addr   = j_reg;
                wr_data   = rd_a_reg;
                dout_next = data_reg ^ (fwd_hit_reg ? fwd_val_reg : rd_b_reg);
            end
            OP_KS_INIT: begin
                i_next   = '0;
                j_next   = '0;
                cnt_next = '0;
                k_next   = '0;
            end
            // identity fill
            OP_KS_FILL: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 8'd1;
            end
            OP_KS_RD_S: begin
                rd_a_en = 1'b1;
            end
            // j += P[s] + key[k], read P[j]
            OP_KS_RD_J: begin
                j_next    = j_reg + rd_a_reg + key_byte;
                rd_b_en   = 1'b1;
                rd_b_addr = j_reg + rd_a_reg + key_byte;
            end
            OP_KS_WR_S: begin
                mem_we  = 1'b1;
                wr_data = rd_b_reg;
            end
            // P[j] = P[s] old; step key index and schedule counter
            OP_KS_WR_J: begin
                mem_we   = 1'b1;
                wr_addr  = j_reg;
                wr_data  = rd_a_reg;
                cnt_next = cnt_reg + 8'd1;
                k_next   = (k_inc >= eff_len) ? '0 : k_inc[KEY_IDX_W-1:0];
                // schedule's j is local: index j reads zero afterwards
                if (cnt_reg == 8'hFF) begin
                    j_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign dp_status.step_last = (cnt_reg == 8'hFF);
    assign m_data_out          = dout_reg;

endmodule

/* rtl/rc4_keystream_cipher.sv */
// RC4 keystream cipher top level: controller plus datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  s_      | in        | s_valid / s_ready  | s_opcode, s_data_in
//  m_      | out       | m_valid / m_ready  | m_data_out
//  cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// A data byte is accepted in IDLE and then steps through D_RD_J, D_WR_I and
// D_WR_J, which registers the result: the read of P[j] waits on the registered
// read of P[i], and the two swap writes share the one memory write port.
// A rekey runs the accepting cycle, the identity fill of all 256 entries and
// 256 schedule steps, each a read of P[s], a read of P[j] and two writes.
// Reset clears indices and control state, zeroes the key words and sets the key
// length to 16; the permutation holds its contents until the first rekey. A
// result waiting on m_ready holds the next data byte in D_WR_J until taken.
module rc4_keystream_cipher
    import rc4_pkg::*;
#(
    parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [7:0]            s_data_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_data_out
);

    dp_op_t     dp_op;
    dp_status_t dp_status;

    rc4_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_op     (dp_op),
        .dp_status (dp_status)
    );

    rc4_dp #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_data_in  (s_data_in),
        .m_data_out (m_data_out),
        .dp_op      (dp_op),
        .dp_status  (dp_status)
    );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the RC4 keystream cipher: rekey and data transfers against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import rc4_pkg::*;

    localparam int REKEY_CYCLES = 1400;          // key schedule plus margin
    localparam int PHASE_OPS    = 45;

    typedef struct {
        logic       opcode;
        logic [7:0] data;
        bit         drain;                       // hold off until all bytes are back
    } cipher_op_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_KEY_WORD_0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_opcode  = OPC_CRYPT;
    logic [7:0]            s_data_in = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [7:0]            m_data_out;

    // Predictor state: permutation, indices, key registers
    logic [7:0]  sbox [256];
    logic [7:0]  ptr_i = '0;
    logic [7:0]  ptr_j = '0;
    logic [63:0] key_words [4] = '{default: '0};
    logic [5:0]  key_len = KEY_LEN_RESET;

    cipher_op_t  op_q [$];
    logic [7:0]  cipher_bytes_q [$];

    bit quiet      = 1'b0;                       // no idling on either side
    int send_gap   = 0;
    int recv_gap   = 0;
    int n_fail     = 0;
    int n_in       = 0;
    int n_rekeys   = 0;
    int n_checked  = 0;
    int n_settings = 0;

    rc4_keystream_cipher u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_data_in  (s_data_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (m_data_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Step the cipher for one accepted transfer; data bytes queue their ciphertext
    function automatic void rc4_advance(input logic opcode, input logic [7:0] din);
        int         len;
        int         k;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] j;
        logic [7:0] t;
        if (opcode == OPC_REKEY) begin
            // zero length acts as one, oversize saturates to the held key
            len = (key_len == 0) ? 1 : ((key_len > KEY_LEN_CAP) ? KEY_LEN_CAP : int'(key_len));
            for (int s = 0; s < 256; s++)
                sbox[s] = 8'(s);
            ptr_i = '0;
            ptr_j = '0;
            j = '0;
            k = 0;
            for (int s = 0; s < 256; s++) begin
                a = sbox[s];
                j = j + a + key_words[k / 8][8 * (k % 8) +: 8];
                sbox[s] = sbox[j];
                sbox[j] = a;
                k++;
                if (k >= len)
                    k = 0;
            end
        end else begin
            ptr_i = ptr_i + 8'd1;
            a = sbox[ptr_i];
            ptr_j = ptr_j + a;
            b = sbox[ptr_j];
            sbox[ptr_i] = b;
            sbox[ptr_j] = a;
            t = a + b;
            cipher_bytes_q.push_back(din ^ sbox[t]);
        end
    endfunction

    function automatic void push_op(input logic opcode, input logic [7:0] data, input bit drain);
        cipher_op_t op;
        op.opcode = opcode;
        op.data   = data;
        op.drain  = drain;
        op_q.push_back(op);
    endfunction

    // One key setting: a rekey, then random bytes with the odd rekey and hold-off
    task automatic load_phase(input int n_ops);
        push_op(OPC_REKEY, 8'($urandom), 1'b0);
        for (int n = 0; n < n_ops; n++)
            push_op(($urandom_range(0, 29) == 0) ? OPC_REKEY : OPC_CRYPT,
                    8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    endtask

    // Write all four key words and the length register, back to back
    task automatic program_key(input logic [63:0] w0, input logic [63:0] w1,
                               input logic [63:0] w2, input logic [63:0] w3,
                               input logic [63:0] len_word);
        logic [63:0] words [4];
        words = '{w0, w1, w2, w3};
        for (int r = 0; r < 5; r++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= (r < 4) ? CFG_KEY_WORD_0 + CFG_IDX_W'(r) : CFG_KEY_LENGTH;
            cfg_wdata <= (r < 4) ? words[r] : len_word;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        key_words = words;
        key_len   = len_word[KEY_LEN_W-1:0];
        n_settings++;
        @(negedge aclk);
    endtask

    // Wait for the block to drain, then let a key schedule finish
    task automatic wait_settled();
        do
            @(negedge aclk);
        while (op_q.size() != 0 || s_valid || cipher_bytes_q.size() != 0);
        repeat (REKEY_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Input driver
    always @(posedge aclk) begin : drive
        cipher_op_t op;
        bit         launch;
        launch = 1'b0;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                rc4_advance(s_opcode, s_data_in);
                n_in++;
                if (s_opcode == OPC_REKEY)
                    n_rekeys++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0)
                    send_gap--;
                else if (!quiet && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 17) - 1;
                else if (op_q.size() != 0 &&
                         !(op_q[0].drain && cipher_bytes_q.size() != 0))
                    launch = 1'b1;
                if (launch) begin
                    op = op_q.pop_front();
                    s_opcode  <= op.opcode;
                    s_data_in <= op.data;
                end
                s_valid <= launch;
            end
        end
    end

    // Result monitor and ready pattern
    always @(posedge aclk) begin : watch
        logic [7:0] want;
        bit         ready_nxt;
        ready_nxt = 1'b0;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (cipher_bytes_q.size() == 0) begin
                    $error("data_out: unexpected transfer, expected none, actual %02h",
                           m_data_out);
                    n_fail++;
                end else begin
                    want = cipher_bytes_q.pop_front();
                    if (m_data_out !== want) begin
                        $error("data_out: expected %02h, actual %02h", want, m_data_out);
                        n_fail++;
                    end
                    n_checked++;
                end
            end
            if (recv_gap > 0)
                recv_gap--;
            else if (!quiet && $urandom_range(0, 11) == 0)
                recv_gap = $urandom_range(1, 17) - 1;
            else
                ready_nxt = 1'b1;
            m_ready <= ready_nxt;
        end
    end

    // Stimulus sequence
    initial begin : sequencer
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset key (all zero, length 16), rekey ignores its data byte
        push_op(OPC_REKEY, 8'hA5, 1'b0);
        push_op(OPC_CRYPT, 8'h00, 1'b0);
        push_op(OPC_CRYPT, 8'hFF, 1'b0);
        push_op(OPC_CRYPT, 8'h01, 1'b0);
        push_op(OPC_CRYPT, 8'h80, 1'b0);
        push_op(OPC_CRYPT, 8'h55, 1'b0);
        push_op(OPC_CRYPT, 8'hAA, 1'b0);
        push_op(OPC_REKEY, 8'hFF, 1'b0);
        push_op(OPC_REKEY, 8'h00, 1'b0);
        push_op(OPC_CRYPT, 8'h00, 1'b0);
        push_op(OPC_CRYPT, 8'h7F, 1'b0);
        push_op(OPC_CRYPT, 8'hFE, 1'b1);
        push_op(OPC_CRYPT, 8'h00, 1'b0);
        wait_settled();

        // Key extremes: all ones at full length, all zero at length one
        program_key('1, '1, '1, '1, 64'd32);
        load_phase(PHASE_OPS);
        wait_settled();
        program_key('0, '0, '0, '0, 64'd1);
        load_phase(PHASE_OPS);
        wait_settled();

        // Short printable key "Key"
        program_key(64'h0000_0000_0079_654B, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, 64'd3);
        load_phase(PHASE_OPS);
        wait_settled();

        // Length zero, length 63 with junk upper bits, length just past the cap
        program_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, 64'd0);
        load_phase(PHASE_OPS);
        wait_settled();
        program_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom} | 64'h3F);
        load_phase(PHASE_OPS);
        wait_settled();
        program_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, 64'd33);
        load_phase(PHASE_OPS);
        wait_settled();

        // Random keys at random legal lengths
        for (int p = 0; p < 3; p++) begin
            program_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, 64'($urandom_range(1, 32)));
            load_phase(PHASE_OPS);
            wait_settled();
        end

        // Closing stretch at full rate
        quiet = 1'b1;
        program_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, 64'($urandom_range(1, 32)));
        load_phase(PHASE_OPS);
        wait_settled();

        $display("tb_top: %0d transfers in (%0d rekeys), %0d bytes checked", n_in, n_rekeys,
                 n_checked);
        $display("tb_top: %0d key settings, lengths 0 to 63 and key extremes", n_settings + 1);
        if (n_fail == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
